// ----- rtl/core/mlfq_pkg.sv -----
package mlfq_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 16;
  localparam int BURST_W = 8;
  localparam int Q_W    = 8;
  localparam int PC_W   = 5;
  localparam int LVL_W  = 2;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [BURST_W-1:0] burst_t;
  typedef logic [Q_W-1:0]     quantum_t;
  typedef logic [PC_W-1:0]    pcount_t;
  typedef logic [LVL_W-1:0]   level_t;

  localparam time_t    TIME_MAX     = '1;
  localparam pcount_t  DONE_MAX     = '1;
  localparam level_t   BOTTOM_LEVEL = 2'd2;
  localparam quantum_t Q0_RESET     = 8'd1;
  localparam quantum_t Q1_RESET     = 8'd2;
  localparam quantum_t Q2_RESET     = 8'd4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_PROCESS_COUNT = 2'd0;
  localparam logic [1:0] REG_QUANTUM0      = 2'd1;
  localparam logic [1:0] REG_QUANTUM1      = 2'd2;
  localparam logic [1:0] REG_QUANTUM2      = 2'd3;

  typedef enum logic {
    ALU_SUB,
    ALU_SUB_SAT
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    time_t   a;
    time_t   b;
  } alu_req_t;

  typedef struct packed {
    time_t res;
    logic  borrow;
  } alu_rsp_t;

endpackage

// ----- rtl/core/mlfq_alu.sv -----
// Shared 16-bit subtractor: arrival compare, turnaround, saturating waiting time.
module mlfq_alu (
  input  mlfq_pkg::alu_req_t req,
  output mlfq_pkg::alu_rsp_t rsp
);

  logic [mlfq_pkg::TIME_W:0] diff;

  always_comb begin
    diff = {1'b0, req.a} - {1'b0, req.b};
    rsp.borrow = diff[mlfq_pkg::TIME_W];
    unique case (req.op)
      mlfq_pkg::ALU_SUB_SAT: begin
        rsp.res = rsp.borrow ? '0 : diff[mlfq_pkg::TIME_W-1:0];
      end
      default: begin
        rsp.res = diff[mlfq_pkg::TIME_W-1:0];
      end
    endcase
  end

endmodule

// ----- rtl/core/mlfq_tick_scheduler.sv -----
// Three-level feedback queue scheduler, one transaction per command.
// Input stream (s_*): s_tuser is the command (0 load a slot, 1 advance one
// tick); s_tdata carries slot, arrival time and burst length for a load.
// Output stream (m_*): exactly one result transaction per input transaction.
// Configuration: APB registers process_count and the three level quanta at
// byte addresses 0, 4, 8, 12; the user must write them only while the block
// is idle, which the block itself does not enforce. A load, or a tick once
// every slot has finished, goes straight to the output register write. Any
// other tick scans slots 0 to count-1, one slot per cycle through the shared
// subtractor, then executes; when the slot finishes, turnaround and then
// waiting are computed on the same subtractor before the output is written.
// The input is not ready while a transaction is in work.
// The result sits in an output register; the next transaction is accepted
// while it waits, and if the receiver stalls, the following result holds in
// the block until the register frees up.
// Reset (synchronous, active high) clears time, finished count, per-slot
// remaining work, levels and used ticks, and restores the register defaults.
// Arrival and burst stores are undefined until loaded.
module mlfq_tick_scheduler (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // slot[3:0], arrival_time[19:4], burst_time[27:20], zero pad
  input  logic [0:0]  s_tuser,   // command[0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // current_time[15:0], run_slot[19:16], run_level[21:20], completion_time[37:22],
  // turnaround[53:38], waiting[69:54], all_done[70], zero pad[71]
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // busy_res[0], finished[1]
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_TAT,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // configuration
  mlfq_pkg::pcount_t  process_count;
  mlfq_pkg::quantum_t quantum0, quantum1, quantum2;

  // scheduler state
  mlfq_pkg::time_t   tick_time;
  mlfq_pkg::pcount_t done_count;
  mlfq_pkg::time_t   arrival_store   [mlfq_pkg::SLOTS];
  mlfq_pkg::burst_t  burst_store     [mlfq_pkg::SLOTS];
  mlfq_pkg::burst_t  remaining_store [mlfq_pkg::SLOTS];
  mlfq_pkg::level_t  level_store     [mlfq_pkg::SLOTS];
  mlfq_pkg::burst_t  used_ticks_store[mlfq_pkg::SLOTS];

  // scan / working registers
  mlfq_pkg::cnt_t   idx;
  mlfq_pkg::slot_t  pick;
  mlfq_pkg::level_t best_level;
  logic             found;
  mlfq_pkg::time_t  r_time, r_ct, r_tat, r_wt;
  logic             r_busy, r_fin, r_all;
  logic [3:0]       r_slot;
  mlfq_pkg::level_t r_level;

  // input fields
  logic [3:0]       in_slot;
  mlfq_pkg::time_t  in_arrival;
  mlfq_pkg::burst_t in_burst;
  logic             in_tick;

  assign in_slot    = s_tdata[3:0];
  assign in_arrival = s_tdata[19:4];
  assign in_burst   = s_tdata[27:20];
  assign in_tick    = s_tuser[0];

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  // slots in use, clipped to the store depth
  mlfq_pkg::cnt_t count;
  logic           all_done_now;
  logic           load_ok;

  assign count = (32'(process_count) > mlfq_pkg::SLOTS) ? mlfq_pkg::cnt_t'(mlfq_pkg::SLOTS)
                                                         : mlfq_pkg::cnt_t'(process_count);
  assign all_done_now = (32'(done_count) >= 32'(count));
  assign load_ok      = (32'(in_slot) < mlfq_pkg::SLOTS);

  // single read port into the slot stores: scan index while scanning, else the pick
  mlfq_pkg::slot_t  rd_idx;
  mlfq_pkg::time_t  rd_arr;
  mlfq_pkg::burst_t rd_burst, rd_rem, rd_used, used_inc;
  mlfq_pkg::level_t rd_level;

  assign rd_idx   = (state == S_SCAN) ? mlfq_pkg::slot_t'(idx) : pick;
  assign rd_arr   = arrival_store[rd_idx];
  assign rd_burst = burst_store[rd_idx];
  assign rd_rem   = remaining_store[rd_idx];
  assign rd_level = level_store[rd_idx];
  assign rd_used  = used_ticks_store[rd_idx];
  assign used_inc = rd_used + 8'd1;   // wraps, so a zero quantum demotes after 256 ticks

  mlfq_pkg::time_t tick_next;
  assign tick_next = (tick_time != mlfq_pkg::TIME_MAX) ? tick_time + 16'd1 : tick_time;

  mlfq_pkg::quantum_t quantum_sel;
  always_comb begin
    unique case (best_level)
      2'd0:    quantum_sel = quantum0;
      2'd1:    quantum_sel = quantum1;
      default: quantum_sel = quantum2;
    endcase
  end

  // shared subtractor
  mlfq_pkg::alu_req_t alu_req;
  mlfq_pkg::alu_rsp_t alu_rsp;

  always_comb begin
    unique case (state)
      S_WAIT: begin
        alu_req.op = mlfq_pkg::ALU_SUB_SAT;    // waiting = turnaround - burst, floor 0
        alu_req.a  = r_tat;
        alu_req.b  = mlfq_pkg::time_t'(rd_burst);
      end
      default: begin
        alu_req.op = mlfq_pkg::ALU_SUB;        // tick_time - arrival
        alu_req.a  = tick_time;
        alu_req.b  = rd_arr;
      end
    endcase
  end

  mlfq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ready: arrived (no borrow) and still has work
  logic scan_ready;
  assign scan_ready = !alu_rsp.borrow && (rd_rem != '0);

  // APB registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= '0;
      quantum0      <= mlfq_pkg::Q0_RESET;
      quantum1      <= mlfq_pkg::Q1_RESET;
      quantum2      <= mlfq_pkg::Q2_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        mlfq_pkg::REG_PROCESS_COUNT: process_count <= pwdata[mlfq_pkg::PC_W-1:0];
        mlfq_pkg::REG_QUANTUM0:      quantum0      <= pwdata[mlfq_pkg::Q_W-1:0];
        mlfq_pkg::REG_QUANTUM1:      quantum1      <= pwdata[mlfq_pkg::Q_W-1:0];
        mlfq_pkg::REG_QUANTUM2:      quantum2      <= pwdata[mlfq_pkg::Q_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mlfq_pkg::REG_PROCESS_COUNT: prdata = 32'(process_count);
      mlfq_pkg::REG_QUANTUM0:      prdata = 32'(quantum0);
      mlfq_pkg::REG_QUANTUM1:      prdata = 32'(quantum1);
      mlfq_pkg::REG_QUANTUM2:      prdata = 32'(quantum2);
    endcase
  end

  // arrival and burst: no reset, written by loads only
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid && !in_tick && load_ok) begin
      arrival_store[mlfq_pkg::slot_t'(in_slot)] <= in_arrival;
      burst_store[mlfq_pkg::slot_t'(in_slot)]   <= in_burst;
    end
  end

  // sequencer, per-slot scheduling state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tick_time        <= '0;
      done_count       <= '0;
      m_tvalid         <= 1'b0;
      remaining_store  <= '{default: '0};
      level_store      <= '{default: '0};
      used_ticks_store <= '{default: '0};
    end else begin
      // S_OUT owns the output register while it loads a new result
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            r_time  <= tick_time;
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_slot  <= '0;
            r_level <= '0;
            r_ct    <= '0;
            r_tat   <= '0;
            r_wt    <= '0;
            if (!in_tick) begin
              if (load_ok) begin
                remaining_store[mlfq_pkg::slot_t'(in_slot)]  <= in_burst;
                level_store[mlfq_pkg::slot_t'(in_slot)]      <= '0;
                used_ticks_store[mlfq_pkg::slot_t'(in_slot)] <= '0;
              end
              r_all <= all_done_now;
              state <= S_OUT;
            end else if (all_done_now) begin
              r_all <= 1'b1;                  // time holds once everything finished
              state <= S_OUT;
            end else begin
              idx        <= '0;
              found      <= 1'b0;
              pick       <= '0;
              best_level <= '0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == count) begin
            state <= S_EXEC;
          end else begin
            // strictly better level wins, so the lowest slot keeps ties
            if (scan_ready && (!found || rd_level < best_level)) begin
              found      <= 1'b1;
              pick       <= rd_idx;
              best_level <= rd_level;
            end
            idx <= idx + 1'b1;
          end
        end
        S_EXEC: begin
          tick_time <= tick_next;
          if (!found) begin
            r_all <= all_done_now;
            state <= S_OUT;
          end else begin
            remaining_store[pick] <= rd_rem - 8'd1;
            r_busy  <= 1'b1;
            r_slot  <= 4'(pick);
            r_level <= best_level;
            if (rd_rem == 8'd1) begin
              used_ticks_store[pick] <= '0;
              if (done_count != mlfq_pkg::DONE_MAX) begin
                done_count <= done_count + 1'b1;
              end
              r_fin <= 1'b1;
              r_ct  <= tick_next;
              state <= S_TAT;
            end else begin
              if (used_inc == quantum_sel) begin
                if (best_level < mlfq_pkg::BOTTOM_LEVEL) begin
                  level_store[pick] <= best_level + 1'b1;
                end
                used_ticks_store[pick] <= '0;
              end else begin
                used_ticks_store[pick] <= used_inc;
              end
              r_all <= all_done_now;
              state <= S_OUT;
            end
          end
        end
        S_TAT: begin
          r_tat <= alu_rsp.res;               // completion - arrival
          state <= S_WAIT;
        end
        S_WAIT: begin
          r_wt  <= alu_rsp.res;
          r_all <= all_done_now;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, r_all, r_wt, r_tat, r_ct, r_level, r_slot, r_time};
            m_tuser  <= {r_fin, r_busy};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a finished slot must also be a busy one
  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("finished result without busy");

  // reported level never beyond the bottom level
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:20] != 2'd3))
    else $error("run_level out of range");

  // time never goes backwards outside reset
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (tick_time >= $past(tick_time)))
    else $error("tick_time went backwards");

  // a finished result implies the finished count moved
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (done_count != '0))
    else $error("finished result with zero done count");

  // scan index stays within the slots in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= count))
    else $error("scan index past slot count");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int NUM_PHASES       = 12;
  localparam int ITEMS_PER_PHASE  = 165;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int STALL_LIMIT      = 3000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int MAX_PRINTED      = 100;
  localparam int CLOSING_ITEMS    = 40;
  // finished count is never lowered; once this many finishes are reached, random
  // traffic tops up slots about to finish, so ticks keep doing real work instead of
  // settling into all done
  localparam int FINISH_RESERVE   = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // one expected result transaction
  typedef struct {
    mlfq_pkg::time_t  current_time;
    logic             busy;
    mlfq_pkg::slot_t  run_slot;
    mlfq_pkg::level_t run_level;
    logic             finished;
    mlfq_pkg::time_t  completion;
    mlfq_pkg::time_t  turnaround;
    mlfq_pkg::time_t  waiting;
    logic             all_done;
  } tick_report_t;

  // Scheduler state mirror: predicts one report per command and checks the
  // block's reports against them in order.
  class schedule_board;
    mlfq_pkg::pcount_t  proc_count;
    mlfq_pkg::quantum_t quanta[3];
    mlfq_pkg::time_t    now;
    mlfq_pkg::pcount_t  done_cnt;
    mlfq_pkg::time_t    arrival[mlfq_pkg::SLOTS];
    mlfq_pkg::burst_t   burst[mlfq_pkg::SLOTS];
    mlfq_pkg::burst_t   remaining[mlfq_pkg::SLOTS];
    mlfq_pkg::level_t   level[mlfq_pkg::SLOTS];
    mlfq_pkg::quantum_t used[mlfq_pkg::SLOTS];
    tick_report_t       pending_reports[$];
    int                 errors;

    function void clear();
      proc_count = '0;
      quanta[0]  = mlfq_pkg::Q0_RESET;
      quanta[1]  = mlfq_pkg::Q1_RESET;
      quanta[2]  = mlfq_pkg::Q2_RESET;
      now        = '0;
      done_cnt   = '0;
      for (int i = 0; i < mlfq_pkg::SLOTS; i++) begin
        arrival[i]   = '0;
        burst[i]     = '0;
        remaining[i] = '0;
        level[i]     = '0;
        used[i]      = '0;
      end
      pending_reports.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        mlfq_pkg::REG_PROCESS_COUNT: proc_count = value[mlfq_pkg::PC_W-1:0];
        mlfq_pkg::REG_QUANTUM0:      quanta[0]  = value[mlfq_pkg::Q_W-1:0];
        mlfq_pkg::REG_QUANTUM1:      quanta[1]  = value[mlfq_pkg::Q_W-1:0];
        mlfq_pkg::REG_QUANTUM2:      quanta[2]  = value[mlfq_pkg::Q_W-1:0];
        default: ;
      endcase
    endfunction

    function int in_use();
      return (int'(proc_count) > mlfq_pkg::SLOTS) ? mlfq_pkg::SLOTS : int'(proc_count);
    endfunction

    function bit all_finished();
      return int'(done_cnt) >= in_use();
    endfunction

    // advance the mirror by one command and queue the report it should give
    function void apply_command(cmd_e cmd, mlfq_pkg::slot_t s, mlfq_pkg::time_t arr,
                                mlfq_pkg::burst_t b);
      tick_report_t     r;
      int               q;
      int               i;
      int               n;
      int               pick;
      bit               found;
      mlfq_pkg::level_t plvl;
      mlfq_pkg::time_t  tat;
      r = '{default: '0};
      r.current_time = now;
      n = in_use();
      found = 1'b0;
      pick = 0;
      plvl = '0;
      if (cmd == CMD_LOAD) begin
        arrival[s]   = arr;
        burst[s]     = b;
        remaining[s] = b;
        level[s]     = '0;
        used[s]      = '0;
      end else if (!all_finished()) begin
        // highest level first, lowest slot first within a level
        for (q = 0; q <= int'(mlfq_pkg::BOTTOM_LEVEL) && !found; q++)
          for (i = 0; i < n && !found; i++)
            if (arrival[i] <= now && remaining[i] != 0 && int'(level[i]) == q) begin
              found = 1'b1;
              pick  = i;
              plvl  = mlfq_pkg::level_t'(q);
            end
        if (found) begin
          remaining[pick]--;
          used[pick]++;
        end
        if (now != mlfq_pkg::TIME_MAX) now++;
        if (found) begin
          r.busy      = 1'b1;
          r.run_slot  = mlfq_pkg::slot_t'(pick);
          r.run_level = plvl;
          if (remaining[pick] == 0) begin
            tat = now - arrival[pick];
            used[pick] = '0;
            if (done_cnt != mlfq_pkg::DONE_MAX) done_cnt++;
            r.finished   = 1'b1;
            r.completion = now;
            r.turnaround = tat;
            // saturated time can leave turnaround below the burst
            r.waiting    = (tat >= mlfq_pkg::time_t'(burst[pick]))
                           ? tat - mlfq_pkg::time_t'(burst[pick]) : '0;
          end else if (used[pick] == quanta[plvl]) begin
            if (level[pick] < mlfq_pkg::BOTTOM_LEVEL) level[pick]++;
            used[pick] = '0;
          end
        end
      end
      r.all_done = all_finished();
      pending_reports.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task compare(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) flag_mismatch(what, got, want);
    endtask

    task check_result(logic [71:0] data, logic [1:0] user);
      tick_report_t want;
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected transaction", data[15:0], '0);
        return;
      end
      want = pending_reports.pop_front();
      compare("current_time",    data[15:0],  want.current_time);
      compare("busy_res",        user[0],     want.busy);
      compare("run_slot",        data[19:16], want.run_slot);
      compare("run_level",       data[21:20], want.run_level);
      compare("finished",        user[1],     want.finished);
      compare("completion_time", data[37:22], want.completion);
      compare("turnaround",      data[53:38], want.turnaround);
      compare("waiting",         data[69:54], want.waiting);
      compare("all_done",        data[70],    want.all_done);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // slot[3:0], arrival_time[19:4], burst_time[27:20], zero pad
  logic [0:0]  s_tuser = '0;   // command[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // current_time[15:0], run_slot[19:16], run_level[21:20], completion_time[37:22],
  // turnaround[53:38], waiting[69:54], all_done[70], zero pad[71]
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;        // busy_res[0], finished[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  schedule_board sb;
  bit tx_idling = 1'b1;      // sender inserts random gaps
  bit rx_idling = 1'b1;      // receiver inserts random stalls
  bit hold_off_req = 1'b0;   // ask the receiver for one long stall

  mlfq_tick_scheduler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command and hold it until the block takes it. tvalid stays up
  // between back-to-back transactions; a gap lowers it in an earlier step.
  task automatic send(cmd_e cmd, mlfq_pkg::slot_t s, mlfq_pkg::time_t arr,
                      mlfq_pkg::burst_t b);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0000, b, arr, s};
    do @(posedge clk); while (!s_tready);
    sb.apply_command(cmd, s, arr, b);
  endtask

  // tick payload is don't-care, so it carries noise
  task automatic send_tick();
    send(CMD_TICK, mlfq_pkg::slot_t'($urandom()), mlfq_pkg::time_t'($urandom()),
         mlfq_pkg::burst_t'($urandom()));
  endtask

  // stop offering and wait until every queued report has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the mirror updates at the
  // edge where the register takes the value
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int count, int q0, int q1, int q2);
    write_reg(mlfq_pkg::REG_PROCESS_COUNT, count);
    write_reg(mlfq_pkg::REG_QUANTUM0, q0);
    write_reg(mlfq_pkg::REG_QUANTUM1, q1);
    write_reg(mlfq_pkg::REG_QUANTUM2, q2);
  endtask

  function automatic int pick_quantum();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 255))
                                       : int'($urandom_range(1, 6));
  endfunction

  // Random command: mostly ticks, loads aimed at slots in use with arrivals
  // near the current time so that slots actually become ready.
  task automatic random_item();
    mlfq_pkg::slot_t  s;
    mlfq_pkg::time_t  arr;
    mlfq_pkg::burst_t b;
    int               n;
    int               a;
    int               i;
    n = sb.in_use();
    if ($urandom_range(0, 99) < 35) begin
      if (n > 0 && $urandom_range(0, 4) != 0) s = mlfq_pkg::slot_t'($urandom_range(0, n - 1));
      else s = mlfq_pkg::slot_t'($urandom_range(0, mlfq_pkg::SLOTS - 1));
      a = int'(sb.now) + int'($urandom_range(0, 16)) - 8;
      if ($urandom_range(0, 7) == 0) arr = mlfq_pkg::time_t'($urandom());
      else if (a < 0) arr = '0;
      else if (a > int'(mlfq_pkg::TIME_MAX)) arr = mlfq_pkg::TIME_MAX;
      else arr = mlfq_pkg::time_t'(a);
      case ($urandom_range(0, 9))
        0:       b = '0;
        1, 2, 3: b = mlfq_pkg::burst_t'($urandom_range(1, 8));
        default: b = mlfq_pkg::burst_t'($urandom_range(9, 255));
      endcase
      send(CMD_LOAD, s, arr, b);
    end else begin
      // out of finish budget: top up any slot one tick from completion
      if (int'(sb.done_cnt) >= FINISH_RESERVE)
        for (i = 0; i < mlfq_pkg::SLOTS; i++)
          if (sb.remaining[i] == 1)
            send(CMD_LOAD, mlfq_pkg::slot_t'(i), sb.arrival[i],
                 mlfq_pkg::burst_t'($urandom_range(2, 255)));
      send_tick();
    end
  endtask

  // output side: one report checked per accepted transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // receiver: random ready/stall bursts, or one long hold-off on request
  initial begin : receiver
    int left;
    bit stalled;
    left = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
        left = 0;
        stalled = 1'b0;
      end else if (!rx_idling) begin
        m_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          stalled = !stalled && ($urandom_range(0, 2) == 0);
          left = stalled ? $urandom_range(1, 11) : $urandom_range(1, 16);
        end
        left--;
        m_tready <= !stalled;
      end
    end
  end

  // watchdog: too long with no transaction on any port ends the run
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int p;
    int k;
    int i;
    int d;
    int count;
    int items;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // nothing in use after reset: a tick reports all done and time holds
    send_tick();
    // fill every slot before any scan can read it
    send(CMD_LOAD, mlfq_pkg::slot_t'(0), mlfq_pkg::time_t'(0),
         mlfq_pkg::burst_t'(1));                                  // finishes on first run
    send(CMD_LOAD, mlfq_pkg::slot_t'(1), mlfq_pkg::time_t'(0),
         mlfq_pkg::burst_t'(5));                                  // walks down to level 2
    send(CMD_LOAD, mlfq_pkg::slot_t'(2), mlfq_pkg::TIME_MAX,
         mlfq_pkg::burst_t'(255));                                // field maxima, never ready
    send(CMD_LOAD, mlfq_pkg::slot_t'(3), mlfq_pkg::time_t'(2),
         mlfq_pkg::burst_t'(0));                                  // zero burst never runs
    send(CMD_LOAD, mlfq_pkg::slot_t'(4), mlfq_pkg::time_t'(1),
         mlfq_pkg::burst_t'(3));                                  // late arrival
    for (i = 5; i < mlfq_pkg::SLOTS; i++)
      send(CMD_LOAD, mlfq_pkg::slot_t'(i), mlfq_pkg::time_t'(16'h8000 | $urandom()),
           mlfq_pkg::burst_t'($urandom_range(1, 255)));
    drain();
    configure(5, int'(mlfq_pkg::Q0_RESET), int'(mlfq_pkg::Q1_RESET),
              int'(mlfq_pkg::Q2_RESET));
    repeat (8) send_tick();

    // --- random phases, each with its own register setting ---
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      d = int'(sb.done_cnt);
      case ($urandom_range(0, 9))
        0:       count = $urandom_range(17, 31);   // above the slot count
        1:       count = $urandom_range(0, d);     // everything already done
        default: count = $urandom_range(d + 1, mlfq_pkg::SLOTS);
      endcase
      items = ITEMS_PER_PHASE;
      case (p)
        0: configure(mlfq_pkg::SLOTS, 1, 1, 1);
        1: configure(31, 255, 255, 255);
        2: configure(17, 0, 0, 0);                 // wrapping used count
        3: begin
          configure(0, 1, 2, 4);
          items = 20;
        end
        default: configure(count, pick_quantum(), pick_quantum(), pick_quantum());
      endcase
      tx_idling = (p % 3 != 2);
      rx_idling = (p % 4 != 1);
      for (k = 0; k < items; k++) begin
        // long receiver stall while commands keep coming: block backs up
        if (p == 4 && k == 30) hold_off_req = 1'b1;
        // sender waits for every outstanding report mid-phase
        if (p == 6 && k == 60) drain();
        random_item();
      end
    end

    // --- closing stretch, no idling from here on ---
    drain();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    configure(mlfq_pkg::SLOTS, 1, 2, 4);
    for (k = 0; k < CLOSING_ITEMS; k++) random_item();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_alu.sv
rtl/core/mlfq_tick_scheduler.sv
test/tb.sv
